// ===== src/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types, codes and constants for the MIDI stream parser.
// ----------------------------------------------------------------------------
package msp_pkg;

    // Parser phases.
    localparam logic [1:0] PH_STATUS = 2'd0;
    localparam logic [1:0] PH_DATA   = 2'd1;
    localparam logic [1:0] PH_SYSEX  = 2'd2;

    // Event kinds.
    localparam logic [4:0] KIND_NONE   = 5'd0;
    localparam logic [4:0] KIND_QFRAME = 5'd7;
    localparam logic [4:0] KIND_TUNE   = 5'd10;
    localparam logic [4:0] KIND_SXBYTE = 5'd11;
    localparam logic [4:0] KIND_SXEND  = 5'd12;
    localparam logic [4:0] KIND_CLOCK  = 5'd13;
    localparam logic [4:0] KIND_START  = 5'd14;
    localparam logic [4:0] KIND_CONT   = 5'd15;
    localparam logic [4:0] KIND_STOP   = 5'd16;
    localparam logic [4:0] KIND_SENSE  = 5'd17;
    localparam logic [4:0] KIND_RESET  = 5'd18;
    localparam logic [4:0] CHAN_BASE   = 5'd8;

    // Byte values of note.
    localparam logic [7:0] RT_BASE    = 8'hf8;
    localparam logic [7:0] SYS_BASE   = 8'hf0;
    localparam logic [7:0] SYSEX_END  = 8'hf7;
    localparam logic [3:0] HI_PROGRAM = 4'hc;
    localparam logic [3:0] HI_PRESS   = 4'hd;

    // System common low nibbles.
    localparam logic [3:0] SC_SYSEX  = 4'h0;
    localparam logic [3:0] SC_QFRAME = 4'h1;
    localparam logic [3:0] SC_SONGPOS = 4'h2;
    localparam logic [3:0] SC_SONGSEL = 4'h3;
    localparam logic [3:0] SC_TUNE   = 4'h6;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [1:0] phase;
        logic [7:0] current_status;
        logic [7:0] running_status;
        logic [1:0] bytes_owed;
        logic [6:0] held_first_byte;
        logic [1:0] message_length;
    } parse_state_t;

    typedef struct packed {
        logic [4:0] event_kind;
        logic [3:0] channel;
        logic [6:0] first_data;
        logic [6:0] second_data;
        logic       last_of_run;
    } event_t;

    // Real-time byte to event kind; undefined codes give KIND_NONE.
    function automatic logic [4:0] rt_kind(input logic [2:0] code);
        logic [4:0] k;
        case (code)
            3'd0:    k = KIND_CLOCK;
            3'd2:    k = KIND_START;
            3'd3:    k = KIND_CONT;
            3'd4:    k = KIND_STOP;
            3'd6:    k = KIND_SENSE;
            3'd7:    k = KIND_RESET;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

// ===== src/msp_decode.sv =====
// ----------------------------------------------------------------------------
// msp_decode
// Combinational decode of one MIDI byte against the parser state, giving
// the next state and up to two events.
// ----------------------------------------------------------------------------
module msp_decode
    import msp_pkg::*;
(
    input  logic [7:0]   byte_in,
    input  parse_state_t state,
    output parse_state_t state_next,
    output logic [1:0]   event_count,
    output event_t       event0,
    output event_t       event1
);

    function automatic parse_state_t take_data_state(input parse_state_t s);
        parse_state_t t;
        t = s;
        if (s.bytes_owed >= 2'd2)
        begin
            t.bytes_owed     = 2'd1;
            t.message_length = 2'd1;
        end
        else
        begin
            t.phase           = PH_STATUS;
            t.bytes_owed      = 2'd0;
            t.message_length  = 2'd0;
            t.held_first_byte = 7'd0;
        end
        return t;
    endfunction

    function automatic event_t take_data_event(input parse_state_t s, input logic [6:0] b);
        event_t e;
        e = '0;
        if (s.current_status < SYS_BASE)
        begin
            e.event_kind = {1'b0, s.current_status[7:4]} - CHAN_BASE;
            e.channel    = s.current_status[3:0];
        end
        else
        begin
            e.event_kind = KIND_QFRAME - 5'd1 + {1'b0, s.current_status[3:0]};
        end
        if (s.message_length != 2'd0)
        begin
            e.first_data  = s.held_first_byte;
            e.second_data = b;
        end
        else
        begin
            e.first_data = b;
        end
        return e;
    endfunction

    function automatic logic [1:0] channel_owed(input logic [3:0] hi);
        return ((hi == HI_PROGRAM) || (hi == HI_PRESS)) ? 2'd1 : 2'd2;
    endfunction

    parse_state_t s;
    event_t       r0;
    event_t       r1;
    logic [1:0]   n;
    event_t       e;
    logic         done;

    always_comb
    begin
        s    = state;
        r0   = '0;
        r1   = '0;
        n    = 2'd0;
        e    = '0;
        done = 1'b0;

        if (byte_in >= RT_BASE)
        begin
            e.event_kind = rt_kind(byte_in[2:0]);
            if (e.event_kind != KIND_NONE)
            begin
                r0 = e;
                n  = 2'd1;
            end
        end
        else if (byte_in[7])
        begin
            if (s.phase == PH_SYSEX)
            begin
                r0.event_kind = KIND_SXEND;
                n             = 2'd1;
                s.phase       = PH_STATUS;
                if (byte_in == SYSEX_END)
                begin
                    s.running_status = 8'd0;
                    s.current_status = byte_in;
                    done             = 1'b1;
                end
            end
            if (!done)
            begin
                s.phase           = PH_STATUS;
                s.bytes_owed      = 2'd0;
                s.message_length  = 2'd0;
                s.held_first_byte = 7'd0;
                s.current_status  = byte_in;
                if (byte_in < SYS_BASE)
                begin
                    s.running_status = byte_in;
                    s.bytes_owed     = channel_owed(byte_in[7:4]);
                    s.phase          = PH_DATA;
                end
                else
                begin
                    s.running_status = 8'd0;
                    case (byte_in[3:0])
                        SC_SYSEX:   s.phase = PH_SYSEX;
                        SC_QFRAME:
                        begin
                            s.bytes_owed = 2'd1;
                            s.phase      = PH_DATA;
                        end
                        SC_SONGPOS:
                        begin
                            s.bytes_owed = 2'd2;
                            s.phase      = PH_DATA;
                        end
                        SC_SONGSEL:
                        begin
                            s.bytes_owed = 2'd1;
                            s.phase      = PH_DATA;
                        end
                        SC_TUNE:
                        begin
                            e.event_kind = KIND_TUNE;
                            if (n == 2'd0)
                                r0 = e;
                            else
                                r1 = e;
                            n = n + 2'd1;
                        end
                        default: ;
                    endcase
                end
            end
        end
        else if (s.phase == PH_SYSEX)
        begin
            r0.event_kind = KIND_SXBYTE;
            r0.first_data = byte_in[6:0];
            n             = 2'd1;
        end
        else if (s.phase == PH_DATA || s.running_status != 8'd0)
        begin
            if (s.phase != PH_DATA)
            begin
                // Running status: reopen a message of the last channel kind.
                s.current_status  = s.running_status;
                s.bytes_owed      = channel_owed(s.running_status[7:4]);
                s.message_length  = 2'd0;
                s.held_first_byte = 7'd0;
                s.phase           = PH_DATA;
            end
            if (s.bytes_owed >= 2'd2)
            begin
                s.held_first_byte = byte_in[6:0];
            end
            else
            begin
                r0 = take_data_event(s, byte_in[6:0]);
                n  = 2'd1;
            end
            s = take_data_state(s);
        end

        if (n == 2'd1)
            r0.last_of_run = 1'b1;
        if (n == 2'd2)
            r1.last_of_run = 1'b1;

        state_next  = s;
        event_count = n;
        event0      = r0;
        event1      = r1;
    end

endmodule

// ===== src/msp_event_fifo.sv =====
// ----------------------------------------------------------------------------
// msp_event_fifo
// Small result queue that takes up to two events per cycle and gives one.
// ----------------------------------------------------------------------------
module msp_event_fifo
    import msp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_count,
    input  event_t     push0,
    input  event_t     push1,
    input  logic       pop,
    output logic       room_for_two,
    output logic       not_empty,
    output event_t     head
);

    event_t entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [PTR_W-1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);
    assign room_for_two = count_reg <= CNT_W'(FIFO_DEPTH - 2);
    assign not_empty    = count_reg != '0;
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            entry_reg[wr_ptr_reg] <= push0;
        if (push_count == 2'd2)
            entry_reg[wr_ptr_plus1] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/midi_stream_parser.sv =====
// ----------------------------------------------------------------------------
// midi_stream_parser
// Decodes a raw MIDI byte stream with running status into events.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+----------------------------------------
//  data    | data_valid / data_stall   | data_byte
//  event   | event_valid / event_stall | event_kind, channel, first_data,
//          |                           | second_data, last_of_run
//
// One byte is accepted per cycle while data_stall is low.  An accepted byte
// sits in the input register, is decoded against the parser state and its
// events are written to a four-entry result queue, from which the first
// event can then be transferred.  A byte that yields two events takes two
// output transfers, so the sustained rate is one byte per cycle while the
// output side takes one event per cycle and the queue has room for two.
// Reset clears the parser state, the input register's full flag and the queue.
// data_stall rises while a byte is held and the queue lacks room for two.
//
module midi_stream_parser
    import msp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       data_valid,
    output logic       data_stall,
    input  logic [7:0] data_byte,
    output logic       event_valid,
    input  logic       event_stall,
    output logic [4:0] event_kind,
    output logic [3:0] channel,
    output logic [6:0] first_data,
    output logic [6:0] second_data,
    output logic       last_of_run
);

    // Input register: holds one byte until the queue can take its events.
    logic         in_full_reg;
    logic         in_full_next;
    logic [7:0]   in_byte_reg;

    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t decoded_state;

    logic [1:0]   dec_count;
    logic [1:0]   push_count;
    event_t       dec_event0;
    event_t       dec_event1;
    event_t       head;
    logic         room_for_two;
    logic         not_empty;
    logic         fire;
    logic         take;
    logic         pop;

    assign fire       = in_full_reg && room_for_two;
    assign data_stall = in_full_reg && !room_for_two;
    assign take       = data_valid && !data_stall;
    assign pop        = not_empty && !event_stall;
    assign push_count = fire ? dec_count : 2'd0;
    assign state_next = fire ? decoded_state : state_reg;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (take)
            in_full_next = 1'b1;
        else if (fire)
            in_full_next = 1'b0;
    end

    msp_decode u_decode (
        .byte_in     (in_byte_reg),
        .state       (state_reg),
        .state_next  (decoded_state),
        .event_count (dec_count),
        .event0      (dec_event0),
        .event1      (dec_event1)
    );

    msp_event_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_count   (push_count),
        .push0        (dec_event0),
        .push1        (dec_event1),
        .pop          (pop),
        .room_for_two (room_for_two),
        .not_empty    (not_empty),
        .head         (head)
    );

    always_ff @(posedge clk)
    begin
        if (take)
            in_byte_reg <= data_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            state_reg   <= '0;
        end
        else
        begin
            in_full_reg <= in_full_next;
            state_reg   <= state_next;
        end
    end

    assign event_valid = not_empty;
    assign event_kind  = head.event_kind;
    assign channel     = head.channel;
    assign first_data  = head.first_data;
    assign second_data = head.second_data;
    assign last_of_run = head.last_of_run;

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the MIDI stream parser: raw bytes go in through a
// queue-fed driver, decoded events are checked in order against a byte-level
// decoder that keeps its own copy of the parser state.
// ----------------------------------------------------------------------------
module testbench;
    import msp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Kinds and byte codes that the package does not name.
    localparam logic [4:0] KIND_SONGPOS = 5'd8;
    localparam logic [4:0] KIND_SONGSEL = 5'd9;
    localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
    localparam logic [3:0] HI_BEND      = 4'he;
    localparam logic [3:0] SC_UNDEF_A   = 4'h4;
    localparam logic [3:0] SC_UNDEF_B   = 4'h5;
    localparam logic [7:0] RT_START     = 8'hfa;
    localparam logic [7:0] RT_CONT      = 8'hfb;
    localparam logic [7:0] RT_STOP      = 8'hfc;
    localparam logic [7:0] RT_SENSE     = 8'hfe;
    localparam logic [7:0] RT_RESET     = 8'hff;

    localparam int RANDOM_PER_PHASE = 252;
    localparam int QUIET_LIMIT      = 2000;
    localparam int TAIL_CYCLES      = 8;
    localparam int REPORT_LIMIT     = 20;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       data_valid  = 1'b0;
    logic       data_stall;
    logic [7:0] data_byte   = 8'h00;
    logic       event_valid;
    logic       event_stall = 1'b0;
    logic [4:0] event_kind;
    logic [3:0] channel;
    logic [6:0] first_data;
    logic [6:0] second_data;
    logic       last_of_run;

    // Bytes waiting to be driven, and events owed by the parser, oldest first.
    logic [7:0] pending[$];
    event_t     events_due[$];

    // Our own copy of the parser state, advanced once per accepted byte.
    logic [1:0] parse_phase = PH_STATUS;
    logic [7:0] cur_status  = 8'h00;
    logic [7:0] run_status  = 8'h00;
    logic [1:0] owed        = 2'd0;
    logic [6:0] held_byte   = 7'd0;
    logic [1:0] got_count   = 2'd0;

    // Running status as the stimulus generator believes it to be.
    logic [7:0] gen_running = 8'h00;

    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int bytes_sent     = 0;
    int events_checked = 0;
    int errors         = 0;
    int quiet_cycles   = 0;
    int queued_items   = 0;

    midi_stream_parser DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_valid  (data_valid),
        .data_stall  (data_stall),
        .data_byte   (data_byte),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_kind  (event_kind),
        .channel     (channel),
        .first_data  (first_data),
        .second_data (second_data),
        .last_of_run (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Byte decoder
    // ------------------------------------------------------------------

    task automatic add_event(input logic [4:0] k, input logic [3:0] ch,
                             input logic [6:0] d1, input logic [6:0] d2);
        event_t e;
        e = {k, ch, d1, d2, 1'b0};
        events_due.push_back(e);
    endtask

    // Program change and channel pressure carry one data byte, the rest two.
    function automatic logic [1:0] channel_need(input logic [7:0] st);
        return (st[7:4] == HI_PROGRAM || st[7:4] == HI_PRESS) ? 2'd1 : 2'd2;
    endfunction

    task automatic open_msg(input logic [7:0] st, input logic [1:0] need);
        cur_status  = st;
        owed        = need;
        got_count   = 2'd0;
        held_byte   = 7'd0;
        parse_phase = PH_DATA;
    endtask

    task automatic take_data(input logic [7:0] b);
        logic [4:0] k;
        logic [3:0] ch;
        logic [6:0] d1;
        logic [6:0] d2;
        if (owed >= 2'd2)
        begin
            // First of two data bytes: hold it until the second arrives.
            held_byte = b[6:0];
            owed      = 2'd1;
            got_count = 2'd1;
        end
        else
        begin
            ch = 4'd0;
            if (cur_status < SYS_BASE)
            begin
                k  = {1'b0, cur_status[7:4]} - CHAN_BASE;
                ch = cur_status[3:0];
            end
            else
            begin
                case (cur_status[3:0])
                    SC_QFRAME:  k = KIND_QFRAME;
                    SC_SONGPOS: k = KIND_SONGPOS;
                    default:    k = KIND_SONGSEL;
                endcase
            end
            d1 = (got_count != 2'd0) ? held_byte : b[6:0];
            d2 = (got_count != 2'd0) ? b[6:0] : 7'd0;
            add_event(k, ch, d1, d2);
            parse_phase = PH_STATUS;
            owed        = 2'd0;
            got_count   = 2'd0;
            held_byte   = 7'd0;
        end
    endtask

    task automatic take_status(input logic [7:0] b);
        parse_phase = PH_STATUS;
        owed        = 2'd0;
        got_count   = 2'd0;
        held_byte   = 7'd0;
        if (b < SYS_BASE)
        begin
            run_status = b;
            open_msg(b, channel_need(b));
        end
        else
        begin
            // Any system common byte cancels running status.
            run_status = 8'h00;
            cur_status = b;
            case (b[3:0])
                SC_SYSEX:               parse_phase = PH_SYSEX;
                SC_QFRAME, SC_SONGSEL:  open_msg(b, 2'd1);
                SC_SONGPOS:             open_msg(b, 2'd2);
                SC_TUNE:                add_event(KIND_TUNE, 4'd0, 7'd0, 7'd0);
                default:                ;
            endcase
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        int     first;
        logic   used_up;
        event_t e;
        first   = events_due.size();
        used_up = 1'b0;
        if (b >= RT_BASE)
        begin
            case (b)
                RT_BASE:  add_event(KIND_CLOCK, 4'd0, 7'd0, 7'd0);
                RT_START: add_event(KIND_START, 4'd0, 7'd0, 7'd0);
                RT_CONT:  add_event(KIND_CONT, 4'd0, 7'd0, 7'd0);
                RT_STOP:  add_event(KIND_STOP, 4'd0, 7'd0, 7'd0);
                RT_SENSE: add_event(KIND_SENSE, 4'd0, 7'd0, 7'd0);
                RT_RESET: add_event(KIND_RESET, 4'd0, 7'd0, 7'd0);
                default:  ;
            endcase
        end
        else if (b[7])
        begin
            if (parse_phase == PH_SYSEX)
            begin
                add_event(KIND_SXEND, 4'd0, 7'd0, 7'd0);
                parse_phase = PH_STATUS;
                if (b == SYSEX_END)
                begin
                    run_status = 8'h00;
                    cur_status = b;
                    used_up    = 1'b1;
                end
            end
            if (!used_up)
                take_status(b);
        end
        else if (parse_phase == PH_SYSEX)
            add_event(KIND_SXBYTE, 4'd0, b[6:0], 7'd0);
        else if (parse_phase == PH_DATA)
            take_data(b);
        else if (run_status != 8'h00)
        begin
            open_msg(run_status, channel_need(run_status));
            take_data(b);
        end
        if (events_due.size() > first)
        begin
            e = events_due.pop_back();
            e.last_of_run = 1'b1;
            events_due.push_back(e);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    // Queues one byte, sometimes with a real-time byte slipped in ahead of it.
    task automatic queue_byte(input logic [7:0] b);
        logic [7:0] rt;
        if ($urandom_range(99) < 8)
        begin
            rt = RT_BASE + 8'($urandom_range(7));
            pending.push_back(rt);
            queued_items++;
        end
        pending.push_back(b);
        queued_items++;
    endtask

    function automatic logic [7:0] random_channel_status();
        logic [7:0] st;
        st[7:4] = 4'($urandom_range(HI_NOTE_OFF, HI_BEND));
        st[3:0] = 4'($urandom_range(15));
        return st;
    endfunction

    task automatic queue_message();
        int         sel;
        int         n;
        int         pick;
        logic [7:0] st;
        logic [7:0] d;
        sel = $urandom_range(99);
        if (sel < 55)
        begin
            // Channel message, often leaning on running status.
            if (gen_running != 8'h00 && $urandom_range(2) == 0)
                st = gen_running;
            else
            begin
                st = random_channel_status();
                queue_byte(st);
            end
            gen_running = st;
            n = channel_need(st);
            repeat (n)
            begin
                d = 8'($urandom_range(127));
                queue_byte(d);
            end
        end
        else if (sel < 70)
        begin
            pick = $urandom_range(5);
            case (pick)
                0:       st = {SYS_BASE[7:4], SC_QFRAME};
                1:       st = {SYS_BASE[7:4], SC_SONGPOS};
                2:       st = {SYS_BASE[7:4], SC_SONGSEL};
                3:       st = {SYS_BASE[7:4], SC_TUNE};
                4:       st = {SYS_BASE[7:4], SC_UNDEF_A};
                default: st = {SYS_BASE[7:4], SC_UNDEF_B};
            endcase
            queue_byte(st);
            gen_running = 8'h00;
            n = (st[3:0] == SC_SONGPOS) ? 2 :
                (st[3:0] == SC_QFRAME || st[3:0] == SC_SONGSEL) ? 1 : 0;
            repeat (n)
            begin
                d = 8'($urandom_range(127));
                queue_byte(d);
            end
        end
        else if (sel < 85)
        begin
            // System exclusive, usually closed properly, sometimes cut short
            // by tune request, a channel status or a fresh start.
            queue_byte({SYS_BASE[7:4], SC_SYSEX});
            gen_running = 8'h00;
            repeat ($urandom_range(6))
            begin
                d = 8'($urandom_range(127));
                queue_byte(d);
            end
            pick = $urandom_range(99);
            if (pick < 70)
                queue_byte(SYSEX_END);
            else if (pick < 80)
                queue_byte({SYS_BASE[7:4], SC_TUNE});
            else if (pick < 90)
            begin
                st = random_channel_status();
                queue_byte(st);
                gen_running = st;
            end
            else
                queue_byte({SYS_BASE[7:4], SC_SYSEX});
        end
        else if (sel < 93)
        begin
            // A message that stops short of its last data byte.
            st = random_channel_status();
            queue_byte(st);
            gen_running = st;
            repeat (channel_need(st) - 1)
            begin
                d = 8'($urandom_range(127));
                queue_byte(d);
            end
        end
        else
        begin
            d = 8'($urandom_range(255));
            queue_byte(d);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offers the next byte, with random idling, once the previous transfer is done.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_valid <= 1'b0;
            data_byte  <= 8'h00;
        end
        else
        begin
            if (data_valid && !data_stall)
            begin
                decode_byte(data_byte);
                bytes_sent++;
            end
            // A stalled byte stays on the port untouched.
            if (!data_valid || !data_stall)
            begin
                if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    data_valid <= 1'b1;
                    data_byte  <= pending.pop_front();
                end
                else
                    data_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks every event transfer against the oldest prediction.
    // ------------------------------------------------------------------

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got && errors < REPORT_LIMIT)
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        event_t want;
        event_t got;
        if (!rst_n)
            event_stall <= 1'b0;
        else
        begin
            if (event_valid && !event_stall)
            begin
                got = {event_kind, channel, first_data, second_data, last_of_run};
                if (events_due.size() == 0)
                begin
                    if (errors < REPORT_LIMIT)
                        $display("%0t ns: unexpected event, expected none, actual kind %0d",
                                 $time, event_kind);
                    errors++;
                end
                else
                begin
                    want = events_due.pop_front();
                    events_checked++;
                    if (got !== want)
                    begin
                        report_field("event_kind", want.event_kind, got.event_kind);
                        report_field("channel", want.channel, got.channel);
                        report_field("first_data", want.first_data, got.first_data);
                        report_field("second_data", want.second_data, got.second_data);
                        report_field("last_of_run", want.last_of_run, got.last_of_run);
                        errors++;
                    end
                end
            end
            event_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog: the run is abandoned if neither channel completes a transfer
    // for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((data_valid && !data_stall) || (event_valid && !event_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int ph;
        int target;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening, run with no idling on either side. After reset
        // there is no running status, so the leading data byte is a stray
        // that must vanish.
        pending = '{8'h00,
                    8'h80, 8'h00, 8'h7f,        // note off, channel 0, extremes
                    8'h9f, 8'h7f, 8'h00,        // note on, channel 15
                    8'h01, 8'hf8, 8'h02,        // running status with clock inside
                    8'h03, 8'ha1,               // half a message, then a new status
                    8'h55, 8'h66,               // poly touch
                    8'hb2, 8'h07, 8'h64,        // control change
                    8'hc3, 8'h7f,               // program change
                    8'hd4, 8'h00,               // channel pressure
                    8'he5, 8'h00, 8'h40,        // pitch bend
                    8'hf1, 8'h3a,               // quarter frame clears running status
                    8'h12,                      // stray data byte again
                    8'hf2, 8'h7f, 8'h7f,        // song position
                    8'hf3, 8'h05,               // song select
                    8'hf6, 8'hf4, 8'hf5, 8'hf7, // tune, undefined, lone end
                    8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff,
                    8'hf0, 8'h00, 8'h7f, 8'hf6, // sysex broken by tune request
                    8'hf0, 8'h44, 8'hf7};       // sysex closed properly

        // Random phases with different idling on each side. Each phase drains
        // completely before the next starts, which also holds the sender
        // back until every outstanding event has been transferred.
        for (ph = 0; ph < 5; ph++)
        begin
            if (ph > 0)
            begin
                send_idle_pct = (ph == 2) ? 67 : (ph == 4) ? 28 : 0;
                stall_pct     = (ph == 3) ? 67 : (ph == 4) ? 28 : 0;
                target = queued_items + RANDOM_PER_PHASE;
                while (queued_items < target)
                    queue_message();
            end
            while (pending.size() != 0 || data_valid)
                @(negedge clk);
            while (events_due.size() != 0)
                @(negedge clk);
        end

        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Covered %0d bytes over four idling mixes; %0d events checked, %0d bad.",
                 bytes_sent, events_checked, errors);
        if (errors == 0 && events_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
